// ===== design/blpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpd_pkg
// Shared types and constants for the button long press detector.
// ----------------------------------------------------------------------------
package blpd_pkg;

    localparam int unsigned NUM_BUTTONS     = 6;
    localparam int unsigned BTN_W           = 8;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned KIND_W          = 2;
    localparam int unsigned CFG_ADDR_W      = 3;
    localparam int unsigned CFG_DATA_W      = 32;
    localparam int unsigned OUT_DATA_W      = 16;
    localparam int unsigned IN_DATA_W       = 40;
    localparam int unsigned FIFO_DEPTH      = 4;

    localparam logic [TIME_W-1:0] LONG_TICKS_RST  = 32'd1000;
    localparam logic [TIME_W-1:0] EXTRA_TICKS_RST = 32'd3000;

    // register indexes, taken from paddr[2]
    localparam logic REG_LONG  = 1'b0;
    localparam logic REG_EXTRA = 1'b1;

    // phase codes double as event kinds
    typedef enum logic [KIND_W-1:0] {
        PH_RELEASE = 2'd0,
        PH_PRESSED = 2'd1,
        PH_LONG    = 2'd2,
        PH_EXTRA   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BTN_W-1:0] id;
        phase_t           kind;
        logic             last;
    } event_t;

    typedef struct packed {
        logic [1:0] cnt;
        event_t     ev0;
        event_t     ev1;
    } push_t;

endpackage

// ===== design/blpd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpd_cfg
// APB threshold registers.
// ----------------------------------------------------------------------------
module blpd_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [blpd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [blpd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [blpd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [blpd_pkg::TIME_W-1:0]          long_ticks,
    output logic [blpd_pkg::TIME_W-1:0]          extra_ticks
);

    logic [blpd_pkg::TIME_W-1:0] long_reg;
    logic [blpd_pkg::TIME_W-1:0] extra_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg  <= blpd_pkg::LONG_TICKS_RST;
            extra_reg <= blpd_pkg::EXTRA_TICKS_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == blpd_pkg::REG_LONG)
            begin
                long_reg <= pwdata;
            end
            else
            begin
                extra_reg <= pwdata;
            end
        end
    end

    assign prdata      = (paddr[2] == blpd_pkg::REG_LONG) ? long_reg : extra_reg;
    assign long_ticks  = long_reg;
    assign extra_ticks = extra_reg;

endmodule

// ===== design/blpd_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpd_eval
// Press state and event generation for one registered poll.
// ----------------------------------------------------------------------------
module blpd_eval
#(
    parameter int unsigned NUM_BUTTONS = blpd_pkg::NUM_BUTTONS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  logic [blpd_pkg::BTN_W-1:0]      raw_button,
    input  logic [blpd_pkg::TIME_W-1:0]     now_time,
    input  logic [blpd_pkg::TIME_W-1:0]     long_ticks,
    input  logic [blpd_pkg::TIME_W-1:0]     extra_ticks,
    output blpd_pkg::push_t                 push
);

    blpd_pkg::phase_t             phase_reg, phase_next;
    logic [blpd_pkg::BTN_W-1:0]   held_reg, held_next;
    logic [blpd_pkg::TIME_W-1:0]  start_reg, start_next;

    // after the press/release step
    blpd_pkg::phase_t             phase_a;
    logic [blpd_pkg::BTN_W-1:0]   held_a;
    logic [blpd_pkg::TIME_W-1:0]  start_a;
    logic                         a_hit;
    logic [blpd_pkg::BTN_W-1:0]   a_id;
    blpd_pkg::phase_t             a_kind;
    logic [blpd_pkg::TIME_W-1:0]  delta;
    logic                         go_long;
    logic                         go_extra;

    logic                         v0, v1;
    blpd_pkg::event_t             e0, e1;

    function automatic logic shown(input logic [blpd_pkg::BTN_W-1:0] b);
        shown = (b != '0) && (b <= blpd_pkg::BTN_W'(NUM_BUTTONS));
    endfunction

    always_comb
    begin
        phase_a = phase_reg;
        held_a  = held_reg;
        start_a = start_reg;
        a_hit   = 1'b0;
        a_id    = held_reg;
        a_kind  = blpd_pkg::PH_RELEASE;
        if (raw_button != '0 && phase_reg == blpd_pkg::PH_RELEASE)
        begin
            held_a  = raw_button;
            start_a = now_time;
            phase_a = blpd_pkg::PH_PRESSED;
            a_hit   = 1'b1;
            a_id    = raw_button;
            a_kind  = blpd_pkg::PH_PRESSED;
        end
        else if (raw_button == '0 && held_reg != '0)
        begin
            phase_a = blpd_pkg::PH_RELEASE;
            held_a  = '0;
            a_hit   = 1'b1;
            a_id    = held_reg;
            a_kind  = blpd_pkg::PH_RELEASE;
        end
        delta    = now_time - start_a;
        go_long  = (phase_a == blpd_pkg::PH_PRESSED) && (delta >= long_ticks);
        go_extra = (phase_a == blpd_pkg::PH_LONG) && (delta >= extra_ticks);
    end

    // next state
    always_comb
    begin
        held_next  = held_a;
        start_next = start_a;
        phase_next = phase_a;
        if (go_long)
        begin
            phase_next = blpd_pkg::PH_LONG;
        end
        else if (go_extra)
        begin
            phase_next = blpd_pkg::PH_EXTRA;
        end
    end

    // events, packed to the front
    always_comb
    begin
        v0      = a_hit && shown(a_id);
        v1      = (go_long || go_extra) && shown(held_a);
        e0.id   = a_id;
        e0.kind = a_kind;
        e0.last = !v1;
        e1.id   = held_a;
        e1.kind = go_long ? blpd_pkg::PH_LONG : blpd_pkg::PH_EXTRA;
        e1.last = 1'b1;
        push    = '0;
        if (take)
        begin
            if (v0)
            begin
                push.ev0 = e0;
                push.ev1 = e1;
                push.cnt = v1 ? 2'd2 : 2'd1;
            end
            else if (v1)
            begin
                push.ev0 = e1;
                push.cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= blpd_pkg::PH_RELEASE;
            held_reg  <= '0;
            start_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            start_reg <= start_next;
        end
    end

    a_held_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == '0) == (phase_reg == blpd_pkg::PH_RELEASE))
        else $error("held button and phase disagree");

    a_two_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> push.ev0.kind == blpd_pkg::PH_PRESSED
            && (push.ev1.kind == blpd_pkg::PH_LONG))
        else $error("bad event pair");

    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |-> push.cnt == 2'd0)
        else $error("event without a poll");

endmodule

// ===== design/blpd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpd_fifo
// Event queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module blpd_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  blpd_pkg::push_t      push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output blpd_pkg::event_t     out_word
);

    localparam int unsigned PTR_W = $clog2(blpd_pkg::FIFO_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    blpd_pkg::event_t  mem [blpd_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pop;
    logic [PTR_W-1:0]  wr_plus;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= CNT_W'(blpd_pkg::FIFO_DEPTH - 2));
    assign out_word  = mem[rd_reg];
    assign wr_plus   = wr_reg + PTR_W'(1);
    assign wr_next   = wr_reg + PTR_W'(push.cnt);
    assign rd_next   = rd_reg + PTR_W'(pop);
    assign cnt_next  = cnt_reg + CNT_W'(push.cnt) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_reg] <= push.ev0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_plus] <= push.ev1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(blpd_pkg::FIFO_DEPTH))
        else $error("queue count out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("write into full queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        PTR_W'(wr_reg - rd_reg) == PTR_W'(cnt_reg))
        else $error("pointers and count disagree");

endmodule

// ===== design/button_long_press_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_long_press_detector_core
// Path: a poll accepted on the input is held in the input register, evaluated, and
// its events are written to the event queue, which feeds the output port word by word.
// Throughput: one poll per cycle while the event queue has room; the one-word output
// port and the 4-word event queue set the pace when polls raise two events.
// Reset: press state cleared, queue emptied, thresholds back to 1000 and 3000.
// ----------------------------------------------------------------------------
module button_long_press_detector_core
#(
    parameter int unsigned NUM_BUTTONS = blpd_pkg::NUM_BUTTONS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [blpd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [blpd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [blpd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [blpd_pkg::IN_DATA_W-1:0]       s_tdata,   // raw_button, now_time
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [blpd_pkg::OUT_DATA_W-1:0]      m_tdata,   // button_id, event_kind, 0 pad
    output logic                                 m_tlast
);

    logic                         in_valid_reg;
    logic [blpd_pkg::BTN_W-1:0]   raw_reg;
    logic [blpd_pkg::TIME_W-1:0]  now_reg;
    logic [blpd_pkg::TIME_W-1:0]  long_ticks;
    logic [blpd_pkg::TIME_W-1:0]  extra_ticks;
    logic                         room;
    logic                         take;
    blpd_pkg::push_t              push;
    blpd_pkg::event_t             out_word;

    assign take     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            raw_reg <= s_tdata[blpd_pkg::BTN_W-1:0];
            now_reg <= s_tdata[blpd_pkg::BTN_W +: blpd_pkg::TIME_W];
        end
    end

    blpd_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .long_ticks  (long_ticks),
        .extra_ticks (extra_ticks)
    );

    blpd_eval
    #(
        .NUM_BUTTONS (NUM_BUTTONS)
    )
    u_eval
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .raw_button  (raw_reg),
        .now_time    (now_reg),
        .long_ticks  (long_ticks),
        .extra_ticks (extra_ticks),
        .push        (push)
    );

    blpd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {6'd0, out_word.kind, out_word.id};
    assign m_tlast = out_word.last;

endmodule

// ===== tb/sv/tb_button_long_press_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_long_press_detector_core
// Self-checking bench for the button long press detector. Polls go in on the
// input stream and events come out on the output stream. A local model of
// the press state and the two thresholds predicts the events of every
// accepted poll, and each event word that comes out is checked field by
// field against the oldest one predicted. Directed polls cover the reset
// thresholds, zero and full-scale thresholds, reversed thresholds, time
// wrap, foreign codes while held and codes above the button count. Random
// press sessions and noise polls follow under several threshold settings,
// with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_button_long_press_detector_core;

    localparam int DRAIN_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 8;
    localparam int RANDOM_POLLS  = 1500;
    localparam int IDLE_PERCENT  = 16;

    typedef struct {
        logic [blpd_pkg::BTN_W-1:0] id;
        blpd_pkg::phase_t           kind;
        logic                       last;
    } btn_event_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [blpd_pkg::CFG_ADDR_W-1:0]      paddr = '0;
    logic [blpd_pkg::CFG_DATA_W-1:0]      pwdata = '0;
    logic [blpd_pkg::CFG_DATA_W-1:0]      prdata;
    logic                                 pready;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [blpd_pkg::IN_DATA_W-1:0]       s_tdata = '0;    // raw_button, now_time
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [blpd_pkg::OUT_DATA_W-1:0]      m_tdata;         // button_id, event_kind, 0 pad
    logic                                 m_tlast;

    // shadow of the block
    logic [blpd_pkg::BTN_W-1:0]           held_code;
    blpd_pkg::phase_t                     hold_phase;
    logic [blpd_pkg::TIME_W-1:0]          press_stamp;
    logic [blpd_pkg::TIME_W-1:0]          long_thr;
    logic [blpd_pkg::TIME_W-1:0]          xlong_thr;

    btn_event_t             pending_events[$];
    btn_event_t             got_event;
    int                     fail_count = 0;
    int                     polls_sent = 0;

    bit                     tx_steady = 1'b0;
    bit                     rx_steady = 1'b0;
    int                     rx_hold_req = 0;
    int                     rx_hold_left = 0;

    button_long_press_detector_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // event prediction
    // ------------------------------------------------------------------
    task automatic predict_poll_events(input logic [blpd_pkg::BTN_W-1:0] code,
                                       input logic [blpd_pkg::TIME_W-1:0] now);
        btn_event_t                  evs[2];
        int                          n;
        logic [blpd_pkg::TIME_W-1:0] elapsed;
        n = 0;
        if (code != 0 && hold_phase == blpd_pkg::PH_RELEASE)
        begin
            held_code   = code;
            press_stamp = now;
            hold_phase  = blpd_pkg::PH_PRESSED;
            if (held_code >= 1 && held_code <= blpd_pkg::NUM_BUTTONS)
            begin
                evs[n] = '{held_code, blpd_pkg::PH_PRESSED, 1'b0};
                n++;
            end
        end
        else if (code == 0 && held_code != 0)
        begin
            hold_phase = blpd_pkg::PH_RELEASE;
            if (held_code >= 1 && held_code <= blpd_pkg::NUM_BUTTONS)
            begin
                evs[n] = '{held_code, blpd_pkg::PH_RELEASE, 1'b0};
                n++;
            end
            held_code = '0;
        end
        if (hold_phase != blpd_pkg::PH_RELEASE)
        begin
            elapsed = now - press_stamp;
            if (hold_phase == blpd_pkg::PH_PRESSED && elapsed >= long_thr)
            begin
                hold_phase = blpd_pkg::PH_LONG;
                if (held_code >= 1 && held_code <= blpd_pkg::NUM_BUTTONS)
                begin
                    evs[n] = '{held_code, blpd_pkg::PH_LONG, 1'b0};
                    n++;
                end
            end
            else if (hold_phase == blpd_pkg::PH_LONG && elapsed >= xlong_thr)
            begin
                hold_phase = blpd_pkg::PH_EXTRA;
                if (held_code >= 1 && held_code <= blpd_pkg::NUM_BUTTONS)
                begin
                    evs[n] = '{held_code, blpd_pkg::PH_EXTRA, 1'b0};
                    n++;
                end
            end
        end
        if (n > 0)
            evs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_events.push_back(evs[i]);
    endtask

    // ------------------------------------------------------------------
    // stream drivers and event checker
    // ------------------------------------------------------------------
    task automatic send_poll(input logic [blpd_pkg::BTN_W-1:0] code,
                             input logic [blpd_pkg::TIME_W-1:0] now);
        while (!tx_steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, code};
        do
            @(posedge clk);
        while (!s_tready);
        predict_poll_events(code, now);
        polls_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rx_steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected word: button_id %0d event_kind %0d last %0b",
                       m_tdata[7:0], m_tdata[9:8], m_tlast);
                fail_count++;
            end
            else
            begin
                got_event = pending_events.pop_front();
                if (m_tdata[7:0] !== got_event.id)
                begin
                    $error("button_id expected %0d got %0d", got_event.id, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[9:8] !== got_event.kind)
                begin
                    $error("event_kind expected %0d got %0d", got_event.kind, m_tdata[9:8]);
                    fail_count++;
                end
                if (m_tlast !== got_event.last)
                begin
                    $error("last_event expected %0b got %0b", got_event.last, m_tlast);
                    fail_count++;
                end
                if (m_tdata[blpd_pkg::OUT_DATA_W-1:10] !== '0)
                begin
                    $error("pad expected 0 got %0h", m_tdata[blpd_pkg::OUT_DATA_W-1:10]);
                    fail_count++;
                end
            end
        end
    end

    task automatic drain_events();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_events.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_events.size());
            fail_count++;
            pending_events.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // write one threshold, then read it back
    task automatic set_threshold(input logic reg_idx,
                                 input logic [blpd_pkg::TIME_W-1:0] value);
        drain_events();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_idx == blpd_pkg::REG_LONG)
            long_thr = value;
        else
            xlong_thr = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            $error("register %0d readback expected %0h got %0h", reg_idx, value, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [blpd_pkg::TIME_W-1:0] lval,
                                  input logic [blpd_pkg::TIME_W-1:0] xval);
        set_threshold(blpd_pkg::REG_LONG, lval);
        set_threshold(blpd_pkg::REG_EXTRA, xval);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_thresholds();
        send_poll(8'd0, 32'd50);
        send_poll(8'd1, 32'd100);
        send_poll(8'd1, 32'd1099);
        send_poll(8'd1, 32'd1100);
        send_poll(8'd1, 32'd3099);
        send_poll(8'd1, 32'd3100);
        send_poll(8'd1, 32'd9000);
        send_poll(8'd0, 32'd9001);
    endtask

    // press and long press in one poll, foreign code while held, untracked codes
    task automatic test_zero_thresholds();
        set_thresholds(32'd0, 32'd0);
        send_poll(8'd6, 32'hFFFF_FFFF);
        send_poll(8'd3, 32'd0);
        send_poll(8'd6, 32'd1);
        send_poll(8'd0, 32'd2);
        send_poll(8'd7, 32'd3);
        send_poll(8'd7, 32'd4);
        send_poll(8'd0, 32'd5);
        send_poll(8'd255, 32'h8000_0000);
        send_poll(8'd0, 32'h8000_0001);
    endtask

    task automatic test_max_thresholds();
        set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_poll(8'd2, 32'd5);
        send_poll(8'd2, 32'd3);
        send_poll(8'd2, 32'd4);
        send_poll(8'd2, 32'd4);
        send_poll(8'd0, 32'd4);
    endtask

    // extra threshold below the long one, across the time wrap
    task automatic test_reversed_thresholds();
        set_thresholds(32'd100, 32'd10);
        send_poll(8'd4, 32'hFFFF_FFC0);
        send_poll(8'd4, 32'h0000_0024);
        send_poll(8'd4, 32'h0000_0024);
        send_poll(8'd0, 32'h0000_0030);
    endtask

    // long output stall while polls keep coming
    task automatic test_backpressure();
        logic [blpd_pkg::TIME_W-1:0] t;
        set_thresholds(32'd0, 32'd5);
        t = $urandom();
        tx_steady   = 1'b1;
        rx_hold_req = 400;
        for (int i = 0; i < 40; i++)
        begin
            send_poll((i % 2 == 0) ? 8'($urandom_range(1, blpd_pkg::NUM_BUTTONS)) : 8'd0, t);
            t = t + 3;
        end
        tx_steady = 1'b0;
        drain_events();
    endtask

    task automatic run_random_phase(input int polls,
                                    input logic [blpd_pkg::TIME_W-1:0] lval,
                                    input logic [blpd_pkg::TIME_W-1:0] xval);
        logic [blpd_pkg::BTN_W-1:0]  code;
        logic [blpd_pkg::TIME_W-1:0] t;
        logic [blpd_pkg::TIME_W-1:0] hi;
        int                          adv_max;
        int                          hold_polls;
        int                          stop_at;
        set_thresholds(lval, xval);
        hi      = (lval > xval) ? lval : xval;
        adv_max = (hi > 32'd1_000_000) ? 24 : int'(hi / 4) + 8;
        stop_at = polls_sent + polls;
        while (polls_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 15)
                send_poll(8'($urandom_range(0, 255)), $urandom());
            else
            begin
                code = ($urandom_range(0, 9) < 7)
                       ? 8'($urandom_range(1, blpd_pkg::NUM_BUTTONS))
                       : 8'($urandom_range(blpd_pkg::NUM_BUTTONS + 1, 255));
                t = $urandom();
                send_poll(code, t);
                hold_polls = $urandom_range(0, 10);
                for (int i = 0; i < hold_polls; i++)
                begin
                    t = t + (($urandom_range(0, 19) == 0) ? $urandom()
                                                          : $urandom_range(0, adv_max));
                    if ($urandom_range(0, 9) == 0)
                        send_poll(8'($urandom_range(1, 255)), t);
                    else
                        send_poll(code, t);
                end
                t = t + $urandom_range(0, adv_max);
                send_poll(8'd0, t);
            end
        end
    endtask

    task automatic test_random_sessions();
        int per_phase;
        per_phase = RANDOM_POLLS / 6;
        run_random_phase(per_phase, 32'd1000, 32'd3000);
        run_random_phase(per_phase, 32'd0, 32'd0);
        run_random_phase(per_phase, $urandom_range(0, 40), $urandom_range(0, 80));
        run_random_phase(per_phase, $urandom_range(20, 60), $urandom_range(0, 19));
        run_random_phase(per_phase, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random_phase(per_phase, $urandom_range(0, 40), $urandom_range(0, 80));
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        held_code   = '0;
        hold_phase  = blpd_pkg::PH_RELEASE;
        press_stamp = '0;
        long_thr    = blpd_pkg::LONG_TICKS_RST;
        xlong_thr   = blpd_pkg::EXTRA_TICKS_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_thresholds();
        test_zero_thresholds();
        test_max_thresholds();
        test_reversed_thresholds();
        test_backpressure();
        test_random_sessions();

        drain_events();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
